@@ hdl/npt_pkg.sv @@
// Package for the node presence table: entry, command and result types,
// operation and status codes, and the constants of the seconds conversion.
// No dependencies; npt_scan, the top level and the testbench import it.
`default_nettype none

package npt_pkg;

	// Default number of slots
	localparam int NPT_SLOTS = 16;

	// Operation codes
	localparam logic [1:0] OP_HEARTBEAT = 2'd0;
	localparam logic [1:0] OP_KEY_FIND  = 2'd1;
	localparam logic [1:0] OP_TYPE_FIND = 2'd2;
	localparam logic [1:0] OP_CLEAR     = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// ms / 1000 = ((ms >> 3) * DIV_RECIP) >> DIV_POST_SHIFT, exact for 32-bit ms
	localparam int          DIV_PRE_SHIFT  = 3;
	localparam logic [29:0] DIV_RECIP      = 30'd549755814;
	localparam int          DIV_POST_SHIFT = 36;
	localparam int          PROD_W         = 59;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [23:0] key;
		logic [7:0]  ntype;
		logic [7:0]  addr;
		logic [7:0]  major;
		logic [7:0]  minor;
		logic [7:0]  revision;
		logic [22:0] seen;
		logic [31:0] beats;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One command item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [23:0] node_key;
		logic [7:0]  packet_type;
		logic [7:0]  query_type;
		logic [7:0]  node_addr;
		logic [7:0]  ver_major;
		logic [7:0]  ver_minor;
		logic [7:0]  ver_revision;
		logic [31:0] time_ms;
	} item_t;

	// One result item
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_index;
		entry_t     entry;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/npt_cmd_if.sv @@
// Command channel of the node presence table: valid, ready and one item.
// Depends on nothing.
`default_nettype none

interface npt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [23:0] node_key;
	logic [7:0]  packet_type;
	logic [7:0]  query_type;
	logic [7:0]  node_addr;
	logic [7:0]  ver_major;
	logic [7:0]  ver_minor;
	logic [7:0]  ver_revision;
	logic [31:0] time_ms;

	modport source (output valid, opcode, node_key, packet_type, query_type, node_addr,
		ver_major, ver_minor, ver_revision, time_ms, input ready);
	modport sink (input valid, opcode, node_key, packet_type, query_type, node_addr,
		ver_major, ver_minor, ver_revision, time_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/npt_rsp_if.sv @@
// Result channel of the node presence table: valid, ready and one result.
// Depends on nothing.
`default_nettype none

interface npt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  slot_index;
	logic [23:0] entry_key;
	logic [7:0]  entry_type;
	logic [7:0]  entry_addr;
	logic [7:0]  entry_major;
	logic [7:0]  entry_minor;
	logic [7:0]  entry_revision;
	logic [22:0] entry_last_seen;
	logic [31:0] entry_beats;

	modport source (output valid, status, slot_index, entry_key, entry_type, entry_addr,
		entry_major, entry_minor, entry_revision, entry_last_seen, entry_beats,
		input ready);
	modport sink (input valid, status, slot_index, entry_key, entry_type, entry_addr,
		entry_major, entry_minor, entry_revision, entry_last_seen, entry_beats,
		output ready);
endinterface

`default_nettype wire

@@ hdl/npt_cfg_if.sv @@
// Configuration write channel of the node presence table: type mask write.
// Depends on nothing.
`default_nettype none

interface npt_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] type_mask;

	modport source (output valid, type_mask, input ready);
	modport sink (input valid, type_mask, output ready);
endinterface

`default_nettype wire

@@ hdl/npt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module npt_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                           wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [W-1:0]                           rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/npt_scan.sv @@
// Sequencer of the node presence table: scans the entry RAM one slot per
// cycle, then writes back a heartbeat. Uses npt_pkg and npt_ram.
`default_nettype none

module npt_scan #(
	parameter int SLOTS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire npt_pkg::item_t item,
	input  wire logic [7:0]     type_mask,
	output logic                idle,
	output logic                res_valid,
	input  wire logic           res_ready,
	output npt_pkg::res_t       res
);
	import npt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_WRITE  = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0]         state_q;
	item_t              item_q;
	logic [CW-1:0]      issue_q;
	logic               pend_s1;
	logic [IW-1:0]      idx_s1;
	logic [SLOTS-1:0]   valid_q;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	entry_t             hit_ent_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic [31:0]        free_beats_q;
	logic [PROD_W-1:0]  prod_q;
	res_t               res_q;

	logic               rd_en;
	logic [ENTRY_W-1:0] rd_raw;
	entry_t             cur;
	logic               key_m;
	logic               free_m;
	logic               ta_m;
	logic               sel_m;
	logic               last_eval;
	logic               wr_en;
	logic [IW-1:0]      wr_idx;
	entry_t             wr_ent;
	logic [31:0]        old_beats;
	logic [IW+3:0]      hit_ext;
	logic [IW+3:0]      wr_ext;

	// Entry store
	npt_ram #(.W(ENTRY_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_ent),
		.re    (rd_en),
		.raddr (issue_q[IW-1:0]),
		.rdata (rd_raw)
	);

	// Read side: entries never written since reset or clear read as zero
	always_comb begin
		rd_en     = (state_q == S_SCAN) && (issue_q != CW'(SLOTS));
		cur       = valid_q[idx_s1] ? entry_t'(rd_raw) : '0;
		key_m     = (item_q.node_key != 24'd0) && (cur.key == item_q.node_key);
		free_m    = (cur.key == 24'd0);
		ta_m      = (cur.ntype == item_q.query_type) && (cur.addr == item_q.node_addr);
		sel_m     = (item_q.opcode == OP_TYPE_FIND) ? ta_m : key_m;
		last_eval = pend_s1 && (idx_s1 == IW'(SLOTS - 1));
	end

	// Heartbeat write-back: key match wins over the first free slot
	always_comb begin
		wr_idx    = hit_q ? hit_idx_q : free_idx_q;
		old_beats = hit_q ? hit_ent_q.beats : free_beats_q;
		wr_en     = (state_q == S_WRITE) && (hit_q || free_q);
		wr_ent.key      = item_q.node_key;
		wr_ent.ntype    = item_q.packet_type & type_mask;
		wr_ent.addr     = item_q.node_addr;
		wr_ent.major    = item_q.ver_major;
		wr_ent.minor    = item_q.ver_minor;
		wr_ent.revision = item_q.ver_revision;
		wr_ent.seen     = prod_q[DIV_POST_SHIFT +: 23];
		wr_ent.beats    = old_beats + 32'd1;
		hit_ext = {4'd0, hit_idx_q};
		wr_ext  = {4'd0, wr_idx};
	end

	// Seconds conversion, one multiply stage off the latched item
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(item_q.time_ms[31:DIV_PRE_SHIFT]) * PROD_W'(DIV_RECIP);
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
		end
		if (rd_en) begin
			idx_s1 <= issue_q[IW-1:0];
		end
		if (pend_s1 && sel_m && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_ent_q <= cur;
		end
		if (pend_s1 && free_m && !free_q) begin
			free_idx_q   <= idx_s1;
			free_beats_q <= cur.beats;
		end
		if (start && (item.opcode == OP_CLEAR)) begin
			res_q <= '{status: ST_OK, slot_index: 4'd0, entry: '0};
		end
		if ((state_q == S_SCAN) && last_eval) begin
			if (hit_q || (pend_s1 && sel_m)) begin
				res_q.status     <= ST_OK;
				res_q.slot_index <= hit_q ? hit_ext[3:0] : 4'(idx_s1);
				res_q.entry      <= hit_q ? hit_ent_q : cur;
			end else begin
				res_q <= '{status: ST_NOT_FOUND, slot_index: 4'd0, entry: '0};
			end
		end
		if (state_q == S_WRITE) begin
			if (hit_q || free_q) begin
				res_q <= '{status: ST_OK, slot_index: wr_ext[3:0], entry: wr_ent};
			end else begin
				res_q <= '{status: ST_FULL, slot_index: 4'd0, entry: '0};
			end
		end
	end

	// Control: state, scan counter, match flags, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						issue_q <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						if (item.opcode == OP_CLEAR) begin
							valid_q <= '0;
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						issue_q <= issue_q + CW'(1);
					end
					if (pend_s1 && sel_m) begin
						hit_q <= 1'b1;
					end
					if (pend_s1 && free_m) begin
						free_q <= 1'b1;
					end
					if (last_eval) begin
						state_q <= (item_q.opcode == OP_HEARTBEAT) ? S_WRITE : S_RESULT;
					end
				end
				S_WRITE: begin
					if (wr_en) begin
						valid_q[wr_idx] <= 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	// Clear drops every valid bit at once
	a_clear_valid: assert property (@(posedge clk) disable iff (!arst_n)
		start && (item.opcode == OP_CLEAR) |=> (valid_q == '0))
		else $error("clear left a slot valid");

	// A heartbeat write marks its slot valid
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(wr_idx)])
		else $error("written slot not marked valid");

	// A dropped heartbeat carries no slot and no entry
	a_full_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_FULL) |-> (res.slot_index == 4'd0) && (res.entry == '0))
		else $error("table full result not blank");

	// The scan read index stays inside the table
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (CW'(idx_s1) < CW'(SLOTS)))
		else $error("scan index out of range");

endmodule

`default_nettype wire

@@ hdl/node_presence_table.sv @@
// Node presence table: a table of SLOTS nodes keyed by a 24-bit hardware
// address. Commands enter on cmd, one result per command leaves on rsp,
// and cfg writes the type mask (reset 0xFF) that masks the heartbeat
// packet type before it is stored.
//
// One command is in work at a time. A search reads every slot of the entry
// RAM, one per cycle, and its result is then loaded into the output
// register; a heartbeat adds a write-back state after the scan, and a clear
// skips the scan. A new command is taken only once the last one has handed
// its result on to the output register. The scan runs over the single read
// port of the RAM.
//
// The output register holds a finished result while rsp is stalled; the
// next command is already taken and scanned, and it waits with its result
// until the register frees up. cfg is always ready; the user writes it only
// while no command is in work, which the block itself does not enforce.
//
// Reset empties the table at once: each slot has a valid bit in flip-flops,
// and a slot never written since reset or clear reads as all zero.
// Depends on npt_pkg, npt_cmd_if, npt_rsp_if, npt_cfg_if and npt_scan.
`default_nettype none

module node_presence_table #(
	parameter int SLOTS = npt_pkg::NPT_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	npt_cmd_if.sink   cmd,
	npt_rsp_if.source rsp,
	npt_cfg_if.sink   cfg
);
	import npt_pkg::*;

	logic [7:0] type_mask_q;
	item_t      item;
	logic       idle;
	logic       start;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	logic       out_valid_q;
	res_t       out_q;

	// Configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_mask_q <= 8'hFF;
		end else if (cfg.valid) begin
			type_mask_q <= cfg.type_mask;
		end
	end

	// Command intake
	always_comb begin
		item.opcode       = cmd.opcode;
		item.node_key     = cmd.node_key;
		item.packet_type  = cmd.packet_type;
		item.query_type   = cmd.query_type;
		item.node_addr    = cmd.node_addr;
		item.ver_major    = cmd.ver_major;
		item.ver_minor    = cmd.ver_minor;
		item.ver_revision = cmd.ver_revision;
		item.time_ms      = cmd.time_ms;
	end
	assign cmd.ready = idle;
	assign start     = cmd.valid && idle;

	npt_scan #(.SLOTS(SLOTS)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.type_mask (type_mask_q),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register
	assign res_ready = !out_valid_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.slot_index      = out_q.slot_index;
	assign rsp.entry_key       = out_q.entry.key;
	assign rsp.entry_type      = out_q.entry.ntype;
	assign rsp.entry_addr      = out_q.entry.addr;
	assign rsp.entry_major     = out_q.entry.major;
	assign rsp.entry_minor     = out_q.entry.minor;
	assign rsp.entry_revision  = out_q.entry.revision;
	assign rsp.entry_last_seen = out_q.entry.seen;
	assign rsp.entry_beats     = out_q.entry.beats;

endmodule

`default_nettype wire

@@ tb/sv/node_presence_table_tb.sv @@
// Testbench for node_presence_table: directed and random commands with a
// self-checking scoreboard that tracks the node table and the type mask.
// Depends on npt_pkg, npt_cmd_if, npt_rsp_if, npt_cfg_if and the block itself.

module node_presence_table_tb;
	import npt_pkg::*;

	// Tracks the node table and checks every result against its own prediction
	class presence_scoreboard;
		entry_t     slots_mem[NPT_SLOTS];
		logic [7:0] mask;
		res_t       predicted_rsp[$];
		int         errors;
		int         n_hb, n_full, n_key, n_type, n_clear;

		function new();
			mask = 8'hFF;
			foreach (slots_mem[i]) slots_mem[i] = '0;
			errors = 0;
			n_hb = 0;
			n_full = 0;
			n_key = 0;
			n_type = 0;
			n_clear = 0;
		endfunction

		// A zero key never matches
		function int find_key(logic [23:0] key);
			if (key == 24'd0) return -1;
			foreach (slots_mem[i])
				if (slots_mem[i].key == key) return i;
			return -1;
		endfunction

		function res_t slot_result(int s);
			res_t r;
			r.status = ST_OK;
			r.slot_index = s[3:0];
			r.entry = slots_mem[s];
			return r;
		endfunction

		// Apply one accepted command and queue its predicted result
		function void note_command(item_t it);
			res_t r;
			int hit;
			logic [31:0] secs;
			r = '0;
			hit = -1;
			case (it.opcode)
				OP_HEARTBEAT: begin
					n_hb++;
					hit = find_key(it.node_key);
					if (hit < 0) begin
						foreach (slots_mem[i])
							if (hit < 0 && slots_mem[i].key == 24'd0) hit = i;
					end
					if (hit < 0) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						secs = it.time_ms / 32'd1000;
						slots_mem[hit].key = it.node_key;
						slots_mem[hit].ntype = it.packet_type & mask;
						slots_mem[hit].addr = it.node_addr;
						slots_mem[hit].major = it.ver_major;
						slots_mem[hit].minor = it.ver_minor;
						slots_mem[hit].revision = it.ver_revision;
						slots_mem[hit].seen = secs[22:0];
						slots_mem[hit].beats = slots_mem[hit].beats + 32'd1;
						r = slot_result(hit);
					end
				end
				OP_KEY_FIND: begin
					n_key++;
					hit = find_key(it.node_key);
					if (hit < 0) r.status = ST_NOT_FOUND;
					else r = slot_result(hit);
				end
				OP_TYPE_FIND: begin
					n_type++;
					// free slots take part in this scan
					foreach (slots_mem[i])
						if (hit < 0 && slots_mem[i].ntype == it.query_type &&
							slots_mem[i].addr == it.node_addr) hit = i;
					if (hit < 0) r.status = ST_NOT_FOUND;
					else r = slot_result(hit);
				end
				default: begin
					n_clear++;
					foreach (slots_mem[i]) slots_mem[i] = '0;
					r.status = ST_OK;
				end
			endcase
			predicted_rsp.push_back(r);
		endfunction

		function void cmp(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: mismatch on %s: expected %0h, actual %0h", $time, what, want, got);
			end
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(res_t got);
			res_t want;
			if (predicted_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual status %0h slot %0h",
					$time, got.status, got.slot_index);
				return;
			end
			want = predicted_rsp.pop_front();
			cmp("status", 32'(want.status), 32'(got.status));
			cmp("slot_index", 32'(want.slot_index), 32'(got.slot_index));
			cmp("entry_key", 32'(want.entry.key), 32'(got.entry.key));
			cmp("entry_type", 32'(want.entry.ntype), 32'(got.entry.ntype));
			cmp("entry_addr", 32'(want.entry.addr), 32'(got.entry.addr));
			cmp("entry_major", 32'(want.entry.major), 32'(got.entry.major));
			cmp("entry_minor", 32'(want.entry.minor), 32'(got.entry.minor));
			cmp("entry_revision", 32'(want.entry.revision), 32'(got.entry.revision));
			cmp("entry_last_seen", 32'(want.entry.seen), 32'(got.entry.seen));
			cmp("entry_beats", want.entry.beats, got.entry.beats);
		endfunction
	endclass

	localparam int PHASES     = 8;
	localparam int PHASE_CMDS = 250;
	localparam int KEY_POOL   = 20;
	localparam int DRAIN_WAIT = 25;

	logic clk;
	logic arst_n;

	npt_cmd_if cmd_ch();
	npt_rsp_if rsp_ch();
	npt_cfg_if cfg_ch();

	node_presence_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	presence_scoreboard sb = new();

	int          cmd_idle_pct;
	int          rsp_stall_pct;
	int          n_masks;
	logic [23:0] key_pool[KEY_POOL];

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Receiver stalls at the falling edge
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Transfer monitor: result first, then new command, then mask write
	always @(posedge clk) begin
		res_t   got;
		item_t  it;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.slot_index = rsp_ch.slot_index;
				got.entry.key = rsp_ch.entry_key;
				got.entry.ntype = rsp_ch.entry_type;
				got.entry.addr = rsp_ch.entry_addr;
				got.entry.major = rsp_ch.entry_major;
				got.entry.minor = rsp_ch.entry_minor;
				got.entry.revision = rsp_ch.entry_revision;
				got.entry.seen = rsp_ch.entry_last_seen;
				got.entry.beats = rsp_ch.entry_beats;
				sb.check_result(got);
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				it.opcode = cmd_ch.opcode;
				it.node_key = cmd_ch.node_key;
				it.packet_type = cmd_ch.packet_type;
				it.query_type = cmd_ch.query_type;
				it.node_addr = cmd_ch.node_addr;
				it.ver_major = cmd_ch.ver_major;
				it.ver_minor = cmd_ch.ver_minor;
				it.ver_revision = cmd_ch.ver_revision;
				it.time_ms = cmd_ch.time_ms;
				sb.note_command(it);
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				sb.mask = cfg_ch.type_mask;
				n_masks++;
			end
		end
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic item_t mk(logic [1:0] op, logic [23:0] key, logic [7:0] ptype,
		logic [7:0] qtype, logic [7:0] addr, logic [7:0] maj, logic [7:0] mnr,
		logic [7:0] rev, logic [31:0] ms);
		item_t it;
		it.opcode = op;
		it.node_key = key;
		it.packet_type = ptype;
		it.query_type = qtype;
		it.node_addr = addr;
		it.ver_major = maj;
		it.ver_minor = mnr;
		it.ver_revision = rev;
		it.time_ms = ms;
		return it;
	endfunction

	// Random command: keys mostly from a small pool so the table fills and matches
	function automatic item_t random_cmd();
		item_t it;
		int pick;
		int s;
		it = mk(2'($urandom_range(3)), 24'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
		pick = $urandom_range(99);
		if (pick < 45) it.opcode = OP_HEARTBEAT;
		else if (pick < 70) it.opcode = OP_KEY_FIND;
		else if (pick < 97) it.opcode = OP_TYPE_FIND;
		else it.opcode = OP_CLEAR;
		pick = $urandom_range(99);
		if (pick < 4) it.node_key = 24'd0;
		else if (pick < 90) it.node_key = key_pool[$urandom_range(KEY_POOL - 1)];
		if ($urandom_range(1)) it.node_addr = 8'($urandom_range(3));
		if (it.opcode == OP_TYPE_FIND && $urandom_range(1)) begin
			s = $urandom_range(NPT_SLOTS - 1);
			it.query_type = sb.slots_mem[s].ntype;
			it.node_addr = sb.slots_mem[s].addr;
		end
		return it;
	endfunction

	// Offer one command; valid stays high into the next call unless it idles
	task automatic send_cmd(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= it.opcode;
		cmd_ch.node_key <= it.node_key;
		cmd_ch.packet_type <= it.packet_type;
		cmd_ch.query_type <= it.query_type;
		cmd_ch.node_addr <= it.node_addr;
		cmd_ch.ver_major <= it.ver_major;
		cmd_ch.ver_minor <= it.ver_minor;
		cmd_ch.ver_revision <= it.ver_revision;
		cmd_ch.time_ms <= it.time_ms;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has been seen
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.predicted_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mask(input logic [7:0] m);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.type_mask <= m;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] mask_plan[PHASES];
		int mode;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_idle_pct = 0;
		rsp_stall_pct = 0;
		n_masks = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_HEARTBEAT;
		cmd_ch.node_key = '0;
		cmd_ch.packet_type = '0;
		cmd_ch.query_type = '0;
		cmd_ch.node_addr = '0;
		cmd_ch.ver_major = '0;
		cmd_ch.ver_minor = '0;
		cmd_ch.ver_revision = '0;
		cmd_ch.time_ms = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.type_mask = '0;
		mask_plan = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h55, 8'($urandom), 8'h00, 8'hFF};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset mask: empty table, extremes, zero key, full table
		send_cmd(mk(OP_TYPE_FIND, 24'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
		send_cmd(mk(OP_KEY_FIND, 24'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		send_cmd(mk(OP_HEARTBEAT, 24'hFF_FFFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			32'hFFFF_FFFF));
		send_cmd(mk(OP_HEARTBEAT, 24'hFF_FFFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
		send_cmd(mk(OP_HEARTBEAT, 24'd0, 8'h5A, 8'h00, 8'h33, 8'h01, 8'h02, 8'h03, 32'd999));
		send_cmd(mk(OP_TYPE_FIND, 24'd0, 8'h00, 8'h5A, 8'h33, 8'h00, 8'h00, 8'h00, 32'd0));
		// keys 1..15 fill slots 1..15, the zero key slot being still free
		for (int k = 1; k < NPT_SLOTS; k++)
			send_cmd(mk(OP_HEARTBEAT, 24'(k), 8'(k * 17), 8'h00, 8'(k), 8'(k), 8'(k + 1),
				8'(k + 2), 32'(k * 1001)));
		send_cmd(mk(OP_HEARTBEAT, 24'h80_0000, 8'h11, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 32'd5000));
		send_cmd(mk(OP_HEARTBEAT, 24'd0, 8'h11, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 32'd5000));
		send_cmd(mk(OP_KEY_FIND, 24'd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
		send_cmd(mk(OP_CLEAR, 24'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));

		// Random phases: new mask and idling mode each phase
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_mask(mask_plan[p]);
			foreach (key_pool[i]) key_pool[i] = 24'($urandom_range(1, 24'hFF_FFFF));
			mode = p % 4;
			for (int i = 0; i < PHASE_CMDS; i++) begin
				// now and then a stretch without idling
				if (i % 40 == 0) begin
					if ($urandom_range(3) == 0 || mode == 0) begin
						cmd_idle_pct = 0;
						rsp_stall_pct = 0;
					end else begin
						cmd_idle_pct = (mode == 1) ? 56 : (mode == 3) ? 34 : 0;
						rsp_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 34 : 0;
					end
				end
				// hold off until the block has delivered everything
				if (i == PHASE_CMDS / 2) drain();
				send_cmd(random_cmd());
			end
		end

		drain();
		$display("Covered %0d commands: %0d heartbeats (%0d dropped on a full table), %0d key searches,",
			sb.n_hb + sb.n_key + sb.n_type + sb.n_clear, sb.n_hb, sb.n_full, sb.n_key);
		$display("%0d type searches, %0d clears; %0d type mask writes; %0d mismatches",
			sb.n_type, sb.n_clear, n_masks, sb.errors);
		if (sb.errors == 0 && sb.predicted_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/npt_pkg.sv
hdl/npt_cmd_if.sv
hdl/npt_rsp_if.sv
hdl/npt_cfg_if.sv
hdl/npt_ram.sv
hdl/npt_scan.sv
hdl/node_presence_table.sv
tb/sv/node_presence_table_tb.sv
